// File: rtl/fan_stall_and_auto_speed_supervisor_assert.svh
// ----------------------------------------------------------------------------
// Fan supervisor assertion macros
// Shared property wrappers for the checker of the fan supervisor.
// ----------------------------------------------------------------------------
`ifndef FAN_STALL_AND_AUTO_SPEED_SUPERVISOR_ASSERT_SVH
`define FAN_STALL_AND_AUTO_SPEED_SUPERVISOR_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent.
`define FSSUP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define FSSUP_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after reset is seen low.
`define FSSUP_ASSERT_RESET(lbl, clk, rstn, cons, msg) \
    lbl: assert property (@(posedge clk) (!rstn) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/fssup_pkg.sv
// ----------------------------------------------------------------------------
// Fan supervisor package
// Shared widths, codes, reset values, types and conversion functions.
// ----------------------------------------------------------------------------
package fssup_pkg;

    // Field widths
    localparam int FUNC_W     = 3;
    localparam int PULSE_W    = 15;
    localparam int DUTY_W     = 8;
    localparam int PCT_IN_W   = 8;
    localparam int PM_W       = 16;
    localparam int TIME_W     = 63;
    localparam int RPM_W      = 21;
    localparam int PCT_W      = 7;
    localparam int ZERO_W     = 4;
    localparam int GRACE_W    = 8;
    localparam int PM_THR_W   = 15;
    localparam int TIMEOUT_W  = 36;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 36;

    // Stream packing
    localparam int S_TDATA_W = 112;
    localparam int S_TUSER_W = FUNC_W;
    localparam int M_TDATA_W = 48;

    localparam int S_PULSE_LSB = 0;
    localparam int S_DUTY_LSB  = S_PULSE_LSB + PULSE_W;
    localparam int S_PCT_LSB   = S_DUTY_LSB + DUTY_W;
    localparam int S_MODE_LSB  = S_PCT_LSB + PCT_IN_W;
    localparam int S_PM_LSB    = S_MODE_LSB + 1;
    localparam int S_TIME_LSB  = S_PM_LSB + PM_W;

    localparam int M_RPM_LSB   = 0;
    localparam int M_STALL_LSB = M_RPM_LSB + RPM_W;
    localparam int M_DUTY_LSB  = M_STALL_LSB + 1;
    localparam int M_PCT_LSB   = M_DUTY_LSB + DUTY_W;
    localparam int M_MODE_LSB  = M_PCT_LSB + PCT_W;
    localparam int M_AUTO_LSB  = M_MODE_LSB + 1;
    localparam int M_USED_W    = M_AUTO_LSB + PCT_W;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_TICK     = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_SET_DUTY = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_SET_PCT  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_SET_MODE = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_PM       = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_TIMEOUT  = 3'd5;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STALL_MIN_DUTY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STALL_LIMIT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRACE_TICKS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PM_LOW         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PM_MED         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PM_HIGH        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MANUAL_TIMEOUT = 3'd6;

    // Modes
    localparam logic MODE_MANUAL = 1'b0;
    localparam logic MODE_AUTO   = 1'b1;

    // Auto speed levels, percent
    localparam logic [PCT_W-1:0] SPEED_LOW  = 7'd25;
    localparam logic [PCT_W-1:0] SPEED_MED  = 7'd50;
    localparam logic [PCT_W-1:0] SPEED_HIGH = 7'd75;
    localparam logic [PCT_W-1:0] SPEED_MAX  = 7'd100;

    localparam int SECONDS_PER_MINUTE = 60;
    localparam int TACH_PPR_DEF       = 2;

    // Reset values
    localparam logic [DUTY_W-1:0]    RST_STALL_MIN_DUTY = 8'd26;
    localparam logic [ZERO_W-1:0]    RST_STALL_LIMIT    = 4'd3;
    localparam logic [GRACE_W-1:0]   RST_GRACE_TICKS    = 8'd5;
    localparam logic [PM_THR_W-1:0]  RST_PM_LOW         = 15'd50;
    localparam logic [PM_THR_W-1:0]  RST_PM_MED         = 15'd150;
    localparam logic [PM_THR_W-1:0]  RST_PM_HIGH        = 15'd250;
    localparam logic [TIMEOUT_W-1:0] RST_MANUAL_TIMEOUT = 36'd21600000000;

    typedef struct packed {
        logic [FUNC_W-1:0]    func;
        logic [PULSE_W-1:0]   tach_pulses;
        logic [DUTY_W-1:0]    duty_value;
        logic [PCT_IN_W-1:0]  percent_value;
        logic                 mode_value;
        logic signed [PM_W-1:0] pm25_tenths;
        logic [TIME_W-1:0]    time_now_us;
    } item_t;

    typedef struct packed {
        logic [DUTY_W-1:0]    stall_min_duty;
        logic [ZERO_W-1:0]    stall_tick_limit;
        logic [GRACE_W-1:0]   grace_ticks;
        logic [PM_THR_W-1:0]  pm_threshold_low;
        logic [PM_THR_W-1:0]  pm_threshold_med;
        logic [PM_THR_W-1:0]  pm_threshold_high;
        logic [TIMEOUT_W-1:0] manual_timeout_us;
    } cfg_t;

    typedef struct packed {
        logic [DUTY_W-1:0]  duty;
        logic [PCT_W-1:0]   pct;
        logic [RPM_W-1:0]   rpm;
        logic [ZERO_W-1:0]  zero_ticks;
        logic               stall;
        logic [GRACE_W-1:0] grace_left;
        logic               mode;
        logic [PCT_W-1:0]   auto_speed;
        logic [TIME_W-1:0]  manual_start;
    } state_t;

    // Rounded percent of a duty: (d*100 + 127) / 255, via reciprocal 257/65536
    function automatic logic [PCT_W-1:0] pct_of_duty(input logic [DUTY_W-1:0] d);
        logic [14:0] x;
        logic [23:0] prod;
        x    = 15'(d) * 15'd100 + 15'd127;
        prod = (24'(x) + 24'd1) * 24'd257;
        return prod[22:16];
    endfunction

    // Duty of a percent (at most 100): p * 255 / 100, rounded down
    function automatic logic [DUTY_W-1:0] duty_of_pct(input logic [PCT_W-1:0] p);
        logic [27:0] prod;
        prod = 28'(p) * 28'd1336965;
        return prod[26:19];
    endfunction

endpackage

// File: rtl/fan_stall_and_auto_speed_supervisor.sv
// ----------------------------------------------------------------------------
// Fan stall and auto speed supervisor
// Tach-based stall detection, duty control and PM2.5 driven auto speed.
// ----------------------------------------------------------------------------
// Path: a transaction accepted at s_ is held in the input register, and its
// status in the status registers. Throughput: one transaction per cycle, held
// by m_tready low, set by the single pass of step logic between the registers.
// Reset: synchronous on aresetn low; clears both valid flags, loads the
// register defaults and the supervisor state (manual mode, auto target 25).
// ----------------------------------------------------------------------------
module fan_stall_and_auto_speed_supervisor #(
    parameter int TACH_PPR = fssup_pkg::TACH_PPR_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    // Input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tach_pulses[14:0], duty_value[22:15], percent_value[30:23],
    // mode_value[31], pm25_tenths[47:32], time_now_us[110:48], zero pad[111]
    input  logic [fssup_pkg::S_TDATA_W-1:0]   s_tdata,
    // func[2:0]
    input  logic [fssup_pkg::S_TUSER_W-1:0]   s_tuser,

    // Status stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // rpm[20:0], stalled[21], duty_now[29:22], speed_percent[36:30],
    // mode_now[37], auto_target[44:38], zero pad[47:45]
    output logic [fssup_pkg::M_TDATA_W-1:0]   m_tdata,

    // Register write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fssup_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fssup_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // Input register stage
    logic              in_valid_reg;
    fssup_pkg::item_t  in_item_reg;
    fssup_pkg::item_t  in_item_next;

    // Supervisor state doubles as the status register: it changes only when a
    // new status is loaded, so it always matches the status being offered.
    fssup_pkg::state_t state_reg;
    fssup_pkg::state_t state_next;
    logic              m_valid_reg;

    fssup_pkg::cfg_t   cfg_reg;

    logic              advance;
    logic              fire;

    // Advance whenever the status slot is empty or being drained
    assign advance  = !m_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    // Unpack the input transaction
    always_comb begin
        in_item_next.func          = s_tuser;
        in_item_next.tach_pulses   = s_tdata[fssup_pkg::S_PULSE_LSB +: fssup_pkg::PULSE_W];
        in_item_next.duty_value    = s_tdata[fssup_pkg::S_DUTY_LSB +: fssup_pkg::DUTY_W];
        in_item_next.percent_value = s_tdata[fssup_pkg::S_PCT_LSB +: fssup_pkg::PCT_IN_W];
        in_item_next.mode_value    = s_tdata[fssup_pkg::S_MODE_LSB];
        in_item_next.pm25_tenths   = s_tdata[fssup_pkg::S_PM_LSB +: fssup_pkg::PM_W];
        in_item_next.time_now_us   = s_tdata[fssup_pkg::S_TIME_LSB +: fssup_pkg::TIME_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Payload holds until the next accepted transaction
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= in_item_next;
        end
    end

    fssup_core #(
        .TACH_PPR (TACH_PPR)
    ) u_core (
        .item_i (in_item_reg),
        .cfg_i  (cfg_reg),
        .st_i   (state_reg),
        .st_o   (state_next)
    );

    // Commit the step and offer its status
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg            <= 1'b0;
            state_reg.duty         <= '0;
            state_reg.pct          <= '0;
            state_reg.rpm          <= '0;
            state_reg.zero_ticks   <= '0;
            state_reg.stall        <= 1'b0;
            state_reg.grace_left   <= '0;
            state_reg.mode         <= fssup_pkg::MODE_MANUAL;
            state_reg.auto_speed   <= fssup_pkg::SPEED_LOW;
            state_reg.manual_start <= '0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
            state_reg   <= state_next;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;

    always_comb begin
        m_tdata = '0;
        m_tdata[fssup_pkg::M_RPM_LSB +: fssup_pkg::RPM_W]   = state_reg.rpm;
        m_tdata[fssup_pkg::M_STALL_LSB]                     = state_reg.stall;
        m_tdata[fssup_pkg::M_DUTY_LSB +: fssup_pkg::DUTY_W] = state_reg.duty;
        m_tdata[fssup_pkg::M_PCT_LSB +: fssup_pkg::PCT_W]   = state_reg.pct;
        m_tdata[fssup_pkg::M_MODE_LSB]                      = state_reg.mode;
        m_tdata[fssup_pkg::M_AUTO_LSB +: fssup_pkg::PCT_W]  = state_reg.auto_speed;
    end

    // Register writes are always taken; unknown indexes drop
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.stall_min_duty    <= fssup_pkg::RST_STALL_MIN_DUTY;
            cfg_reg.stall_tick_limit  <= fssup_pkg::RST_STALL_LIMIT;
            cfg_reg.grace_ticks       <= fssup_pkg::RST_GRACE_TICKS;
            cfg_reg.pm_threshold_low  <= fssup_pkg::RST_PM_LOW;
            cfg_reg.pm_threshold_med  <= fssup_pkg::RST_PM_MED;
            cfg_reg.pm_threshold_high <= fssup_pkg::RST_PM_HIGH;
            cfg_reg.manual_timeout_us <= fssup_pkg::RST_MANUAL_TIMEOUT;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                fssup_pkg::REG_STALL_MIN_DUTY: begin
                    cfg_reg.stall_min_duty <= cfg_data[fssup_pkg::DUTY_W-1:0];
                end
                fssup_pkg::REG_STALL_LIMIT: begin
                    cfg_reg.stall_tick_limit <= cfg_data[fssup_pkg::ZERO_W-1:0];
                end
                fssup_pkg::REG_GRACE_TICKS: begin
                    cfg_reg.grace_ticks <= cfg_data[fssup_pkg::GRACE_W-1:0];
                end
                fssup_pkg::REG_PM_LOW: begin
                    cfg_reg.pm_threshold_low <= cfg_data[fssup_pkg::PM_THR_W-1:0];
                end
                fssup_pkg::REG_PM_MED: begin
                    cfg_reg.pm_threshold_med <= cfg_data[fssup_pkg::PM_THR_W-1:0];
                end
                fssup_pkg::REG_PM_HIGH: begin
                    cfg_reg.pm_threshold_high <= cfg_data[fssup_pkg::PM_THR_W-1:0];
                end
                fssup_pkg::REG_MANUAL_TIMEOUT: begin
                    cfg_reg.manual_timeout_us <= cfg_data[fssup_pkg::TIMEOUT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// File: rtl/fssup_core.sv
// ----------------------------------------------------------------------------
// Fan supervisor step logic
// Next state of the supervisor for one transaction, purely combinational.
// ----------------------------------------------------------------------------
module fssup_core #(
    parameter int TACH_PPR = fssup_pkg::TACH_PPR_DEF
) (
    input  fssup_pkg::item_t  item_i,
    input  fssup_pkg::cfg_t   cfg_i,
    input  fssup_pkg::state_t st_i,
    output fssup_pkg::state_t st_o
);

    localparam int RpmScale = fssup_pkg::SECONDS_PER_MINUTE / TACH_PPR;

    logic [fssup_pkg::RPM_W-1:0]  rpm_calc;
    logic [fssup_pkg::PCT_W-1:0]  pct_clamp;
    logic [fssup_pkg::PCT_W-1:0]  pm_target;
    logic [fssup_pkg::PCT_W-1:0]  pct_sel;
    logic [fssup_pkg::DUTY_W-1:0] duty_from_pct;
    logic [fssup_pkg::DUTY_W-1:0] duty_req;
    logic [fssup_pkg::PCT_W-1:0]  pct_req;
    logic                         apply;
    logic [fssup_pkg::ZERO_W-1:0] zero_inc;
    logic [63:0]                  elapsed;
    logic                         timed_out;

    assign rpm_calc = fssup_pkg::RPM_W'(item_i.tach_pulses) * fssup_pkg::RPM_W'(RpmScale);

    assign pct_clamp = (item_i.percent_value > 8'd100) ? fssup_pkg::SPEED_MAX
                                                       : item_i.percent_value[6:0];

    // Negative reading is a sensor error: fall to the lowest level
    always_comb begin
        if (item_i.pm25_tenths[fssup_pkg::PM_W-1]) begin
            pm_target = fssup_pkg::SPEED_LOW;
        end else if (item_i.pm25_tenths[14:0] < cfg_i.pm_threshold_low) begin
            pm_target = fssup_pkg::SPEED_LOW;
        end else if (item_i.pm25_tenths[14:0] < cfg_i.pm_threshold_med) begin
            pm_target = fssup_pkg::SPEED_MED;
        end else if (item_i.pm25_tenths[14:0] < cfg_i.pm_threshold_high) begin
            pm_target = fssup_pkg::SPEED_HIGH;
        end else begin
            pm_target = fssup_pkg::SPEED_MAX;
        end
    end

    always_comb begin
        case (item_i.func)
            fssup_pkg::FUNC_SET_PCT: pct_sel = pct_clamp;
            fssup_pkg::FUNC_PM:      pct_sel = pm_target;
            default:                 pct_sel = st_i.auto_speed;
        endcase
    end

    assign duty_from_pct = fssup_pkg::duty_of_pct(pct_sel);

    assign zero_inc = (st_i.zero_ticks == 4'hF) ? st_i.zero_ticks : st_i.zero_ticks + 4'd1;

    // Time running backwards gives no timeout
    assign elapsed   = {1'b0, item_i.time_now_us} - {1'b0, st_i.manual_start};
    assign timed_out = !elapsed[63] &&
                       (elapsed[62:0] >= 63'(cfg_i.manual_timeout_us));

    always_comb begin
        st_o     = st_i;
        apply    = 1'b0;
        duty_req = duty_from_pct;
        pct_req  = pct_sel;
        case (item_i.func)
            fssup_pkg::FUNC_TICK: begin
                st_o.rpm = rpm_calc;
                if (st_i.grace_left != '0) begin
                    st_o.grace_left = st_i.grace_left - 8'd1;
                end
                if (st_i.grace_left == '0 && item_i.tach_pulses == '0 &&
                    st_i.duty >= cfg_i.stall_min_duty) begin
                    st_o.zero_ticks = zero_inc;
                    if (zero_inc >= cfg_i.stall_tick_limit) begin
                        st_o.stall = 1'b1;
                    end
                end else begin
                    st_o.zero_ticks = '0;
                    if (item_i.tach_pulses != '0) begin
                        st_o.stall = 1'b0;
                    end
                end
            end
            fssup_pkg::FUNC_SET_DUTY: begin
                apply    = 1'b1;
                duty_req = item_i.duty_value;
                pct_req  = fssup_pkg::pct_of_duty(item_i.duty_value);
            end
            fssup_pkg::FUNC_SET_PCT: begin
                apply = 1'b1;
            end
            fssup_pkg::FUNC_SET_MODE: begin
                st_o.mode = item_i.mode_value;
                if (item_i.mode_value == fssup_pkg::MODE_MANUAL) begin
                    st_o.manual_start = item_i.time_now_us;
                end else if (st_i.mode == fssup_pkg::MODE_MANUAL) begin
                    apply = 1'b1;
                end
            end
            fssup_pkg::FUNC_PM: begin
                if (st_i.mode == fssup_pkg::MODE_AUTO && pm_target != st_i.auto_speed) begin
                    st_o.auto_speed = pm_target;
                    apply           = 1'b1;
                end
            end
            fssup_pkg::FUNC_TIMEOUT: begin
                if (st_i.mode == fssup_pkg::MODE_MANUAL && timed_out) begin
                    st_o.mode = fssup_pkg::MODE_AUTO;
                    apply     = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (apply) begin
            st_o.duty = duty_req;
            st_o.pct  = pct_req;
            if (duty_req < cfg_i.stall_min_duty) begin
                st_o.zero_ticks = '0;
                st_o.stall      = 1'b0;
            end
            if (st_i.duty < cfg_i.stall_min_duty && duty_req >= cfg_i.stall_min_duty) begin
                st_o.grace_left = cfg_i.grace_ticks;
                st_o.zero_ticks = '0;
            end
        end
    end

endmodule

// File: rtl/fssup_checker.sv
// ----------------------------------------------------------------------------
// Fan supervisor port checker
// Port-level properties of the supervisor, bound to the top level.
// ----------------------------------------------------------------------------
`include "fan_stall_and_auto_speed_supervisor_assert.svh"

module fssup_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [fssup_pkg::M_TDATA_W-1:0] m_tdata
);

    logic [fssup_pkg::RPM_W-1:0] rpm_f;
    logic                        stall_f;
    logic [fssup_pkg::PCT_W-1:0] pct_f;
    logic [fssup_pkg::PCT_W-1:0] auto_f;
    logic                        levels_ok;

    assign rpm_f   = m_tdata[fssup_pkg::M_RPM_LSB +: fssup_pkg::RPM_W];
    assign stall_f = m_tdata[fssup_pkg::M_STALL_LSB];
    assign pct_f   = m_tdata[fssup_pkg::M_PCT_LSB +: fssup_pkg::PCT_W];
    assign auto_f  = m_tdata[fssup_pkg::M_AUTO_LSB +: fssup_pkg::PCT_W];

    assign levels_ok = (pct_f <= fssup_pkg::SPEED_MAX) &&
                       (auto_f == fssup_pkg::SPEED_LOW || auto_f == fssup_pkg::SPEED_MED ||
                        auto_f == fssup_pkg::SPEED_HIGH || auto_f == fssup_pkg::SPEED_MAX);

    // Stalled status holds its transaction
    `FSSUP_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "status changed while stalled")

    `FSSUP_ASSERT_RESET(a_rst, aclk, aresetn, !m_tvalid, "status valid right after reset")

    // Input only backs up behind a waiting status
    `FSSUP_ASSERT_NOW(a_ready, aclk, aresetn, !s_tready, m_tvalid, "input blocked with no status pending")

    // A declared stall always comes with zero speed
    `FSSUP_ASSERT_NOW(a_stall, aclk, aresetn, m_tvalid && stall_f, rpm_f == '0,
        "stall flagged with nonzero rpm")

    `FSSUP_ASSERT_NOW(a_levels, aclk, aresetn, m_tvalid, levels_ok,
        "percent or auto target out of range")

endmodule

bind fan_stall_and_auto_speed_supervisor fssup_checker u_fssup_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
